>>> sv/utrx_pkg.sv
// Shared types and constants for the 8N1 UART transceiver with receive FIFO.
`default_nettype none

package utrx_pkg;

	// Bit period register and divider widths
	localparam int unsigned PERIOD_W = 17;
	localparam int unsigned DIV_W = 16;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd625;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = 17'd65536;

	// Width of the fill count shown on the result beat
	localparam int unsigned COUNT_W = 5;

	// One input beat: pin level and host requests for one clock of the serial side
	typedef struct packed {
		logic       rx_level;
		logic       tx_start;
		logic [7:0] tx_data;
		logic       pop_req;
	} in_item_t;

	// One result beat: pin and status view after the update
	typedef struct packed {
		logic                tx_line;
		logic                tx_busy;
		logic                tx_done;
		logic                rx_busy;
		logic [7:0]          rx_head;
		logic [COUNT_W-1:0]  rx_count;
		logic                rx_dropped;
	} out_item_t;

	// Serial engine status after the update
	typedef struct packed {
		logic tx_line;
		logic tx_busy;
		logic tx_done;
		logic rx_busy;
	} serial_stat_t;

	// Received byte handed to the FIFO
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} push_t;

	// FIFO view after the update
	typedef struct packed {
		logic               dropped;
		logic [7:0]         head;
		logic [COUNT_W-1:0] count;
	} fifo_stat_t;

endpackage

`default_nettype wire

>>> sv/utrx_serial.sv
// Bit-period divider plus transmit and receive frame sequencers.
`default_nettype none

module utrx_serial (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire utrx_pkg::in_item_t            item,
	input  wire logic [utrx_pkg::PERIOD_W-1:0] period,
	output utrx_pkg::serial_stat_t             stat,
	output utrx_pkg::push_t                    push
);

	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_START = 4'd1;
	localparam logic [3:0] PH_D0    = 4'd2;
	localparam logic [3:0] PH_STOP  = 4'd10;

	logic [3:0]                   tx_phase_q, rx_phase_q;
	logic [7:0]                   tx_shift_q, rx_shift_q;
	logic                         tx_level_q, rx_prev_q;
	logic [utrx_pkg::DIV_W-1:0]   div_q;

	logic [3:0]                   tx_phase_d, rx_phase_d, rx_inc, tx_inc, tx_tmp;
	logic [7:0]                   tx_shift_d, rx_shift_d;
	logic                         tx_level_d, running, tick, done;
	logic [utrx_pkg::DIV_W-1:0]   div_d;
	logic [utrx_pkg::PERIOD_W-1:0] div_inc;
	logic [3:0]                   rx_bit, tx_bit;

	// Next state for one serial clock
	always_comb begin
		running    = (tx_phase_q != PH_IDLE) || (rx_phase_q != PH_IDLE);
		div_inc    = {1'b0, div_q} + 1'b1;
		tick       = running && (div_inc >= period);
		div_d      = div_q;
		if (running) begin
			div_d = tick ? '0 : div_inc[utrx_pkg::DIV_W-1:0];
		end

		// receiver: ticks one to eight sample data, the ninth ends the frame
		rx_phase_d = rx_phase_q;
		rx_shift_d = rx_shift_q;
		push.valid = 1'b0;
		push.data  = rx_shift_q;
		rx_inc     = rx_phase_q + 4'd1;
		rx_bit     = rx_inc - PH_D0;
		if (tick && (rx_phase_q != PH_IDLE)) begin
			if (rx_inc >= PH_STOP) begin
				rx_phase_d = PH_IDLE;
				push.valid = 1'b1;
			end else begin
				rx_phase_d = rx_inc;
				rx_shift_d[rx_bit[2:0]] = item.rx_level;
			end
		end

		// transmitter: stop bit ends, then advance to the next level
		tx_tmp     = tx_phase_q;
		done       = 1'b0;
		tx_level_d = tx_level_q;
		tx_inc     = tx_phase_q + 4'd1;
		tx_bit     = tx_inc - PH_D0;
		if (tick) begin
			if (tx_phase_q >= PH_STOP) begin
				tx_tmp = PH_IDLE;
				done   = 1'b1;
			end else if (tx_phase_q != PH_IDLE) begin
				if (tx_inc >= PH_STOP) begin
					tx_tmp     = PH_STOP;
					tx_level_d = 1'b1;
				end else begin
					tx_tmp     = tx_inc;
					tx_level_d = tx_shift_q[tx_bit[2:0]];
				end
			end
		end
		tx_phase_d = tx_tmp;
		tx_shift_d = tx_shift_q;

		// falling edge on an idle receiver opens a frame
		if ((rx_phase_d == PH_IDLE) && rx_prev_q && !item.rx_level) begin
			rx_phase_d = PH_START;
			rx_shift_d = '0;
		end

		// transmit request taken only when idle
		if (item.tx_start && (tx_phase_d == PH_IDLE)) begin
			tx_phase_d = PH_START;
			tx_shift_d = item.tx_data;
			tx_level_d = 1'b0;
		end

		// divider rests at zero while both sides are idle
		if ((tx_phase_d == PH_IDLE) && (rx_phase_d == PH_IDLE)) begin
			div_d = '0;
		end

		stat.tx_line = tx_level_d;
		stat.tx_busy = (tx_phase_d != PH_IDLE);
		stat.tx_done = done;
		stat.rx_busy = (rx_phase_d != PH_IDLE);
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_phase_q <= PH_IDLE;
			tx_shift_q <= '0;
			tx_level_q <= 1'b1;
			rx_phase_q <= PH_IDLE;
			rx_shift_q <= '0;
			rx_prev_q  <= 1'b1;
			div_q      <= '0;
		end else if (fire) begin
			tx_phase_q <= tx_phase_d;
			tx_shift_q <= tx_shift_d;
			tx_level_q <= tx_level_d;
			rx_phase_q <= rx_phase_d;
			rx_shift_q <= rx_shift_d;
			rx_prev_q  <= item.rx_level;
			div_q      <= div_d;
		end
	end

endmodule

`default_nettype wire

>>> sv/utrx_fifo.sv
// Receive FIFO: drops its oldest byte when full, head byte kept in a register.
`default_nettype none

module utrx_fifo #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire logic           pop,
	input  wire utrx_pkg::push_t push,
	output utrx_pkg::fifo_stat_t stat
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned FW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [FW-1:0] FULL = FW'(DEPTH);
	localparam logic [FW:0]   DEPTH_X = (FW + 1)'(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [7:0]    head_val_q;
	logic [7:0]    next_val_q;   // entry just after the head

	logic [AW-1:0] head1, head_d, head_eff, waddr, raddr;
	logic [FW-1:0] fill_a, fill_b, fill_d;
	logic [FW:0]   wsum;
	logic          pop_ok, drop, advance, we;
	logic [7:0]    head_val_d;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
		return (a == LAST) ? '0 : a + 1'b1;
	endfunction

	// Pop first, then push with drop of the oldest when still full
	always_comb begin
		head1   = wrap_inc(head_q);
		pop_ok  = pop && (fill_q != '0);
		fill_a  = fill_q - FW'(pop_ok);
		drop    = push.valid && (fill_a == FULL);
		advance = pop_ok || drop;
		head_d  = advance ? head1 : head_q;
		fill_b  = drop ? (FULL - 1'b1) : fill_a;
		fill_d  = fill_b + FW'(push.valid);

		wsum  = {{(FW + 1 - AW){1'b0}}, head_d} + {1'b0, fill_b};
		waddr = (wsum >= DEPTH_X) ? AW'(wsum - DEPTH_X) : wsum[AW-1:0];
		we    = fire && push.valid;

		if (push.valid && (waddr == head_d)) begin
			head_val_d = push.data;
		end else if (advance) begin
			head_val_d = next_val_q;
		end else begin
			head_val_d = head_val_q;
		end

		head_eff = fire ? head_d : head_q;
		raddr    = wrap_inc(head_eff);

		stat.dropped = drop;
		stat.head    = (fill_d != '0) ? head_val_d : 8'd0;
		stat.count   = fill_d[utrx_pkg::COUNT_W-1:0];
	end

	// Storage: one write, one registered read of the entry after the head
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= push.data;
		end
		if (we && (waddr == raddr)) begin
			next_val_q <= push.data;
		end else begin
			next_val_q <= mem[raddr];
		end
		if (fire) begin
			head_val_q <= head_val_d;
		end
	end

	// Pointer and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (fire) begin
			head_q <= head_d;
			fill_q <= fill_d;
		end
	end

endmodule

`default_nettype wire

>>> sv/uart_8n1_tx_rx_with_fifo.sv
// Top level of the 8N1 UART transceiver with receive FIFO.
// Usage:
//   Input channel (in_valid/in_stall/in_item): one beat per serial clock, carrying
//   the receive pin level, a transmit request with its byte, and a FIFO pop request.
//   Output channel (out_valid/out_stall/out_item): one beat per input beat, giving
//   transmit pin level, busy/done flags, the FIFO head byte, fill count and drop pulse.
//   Configuration channel (cfg_valid/cfg_ready/cfg_data): writes the bit period in
//   clocks; 0 acts as 1 and values above 65536 are held at 65536. Write only when idle.
// Pipeline: an accepted beat waits in the input register; when the update fires,
//   its result is written to the result register and offered on out_item.
// Throughput: one beat per cycle while the output is not stalled; the frame
//   sequencers and the FIFO pointers complete their update on every fired beat.
// Reset: transmit line high, both directions idle, divider zero, FIFO empty,
//   bit period 625. The FIFO storage itself is not cleared.
// When the receiver stalls the result holds, the input register fills and
//   in_stall rises; no beat is lost or repeated.
`default_nettype none

module uart_8n1_tx_rx_with_fifo #(
	parameter int unsigned FIFO_DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire utrx_pkg::in_item_t            in_item,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output utrx_pkg::out_item_t                out_item,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [utrx_pkg::PERIOD_W-1:0] cfg_data
);

	logic                          valid_s1;
	utrx_pkg::in_item_t            item_s1;
	logic                          out_valid_q;
	utrx_pkg::out_item_t           out_item_q;
	logic [utrx_pkg::PERIOD_W-1:0] period_q;

	logic                          fire;
	utrx_pkg::serial_stat_t        ser_stat;
	utrx_pkg::push_t               push;
	utrx_pkg::fifo_stat_t          fifo_stat;

	// Handshake: the update fires when the result register is free or draining
	assign fire      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !fire;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign cfg_ready = 1'b1;

	// Bit period register, clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= utrx_pkg::PERIOD_RESET;
		end else if (cfg_valid) begin
			period_q <= (cfg_data > utrx_pkg::PERIOD_MAX) ? utrx_pkg::PERIOD_MAX : cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (in_valid && !in_stall) || in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	utrx_serial u_serial (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.period (period_q),
		.stat   (ser_stat),
		.push   (push)
	);

	utrx_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.pop    (item_s1.pop_req),
		.push   (push),
		.stat   (fifo_stat)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_item_q.tx_line    <= ser_stat.tx_line;
			out_item_q.tx_busy    <= ser_stat.tx_busy;
			out_item_q.tx_done    <= ser_stat.tx_done;
			out_item_q.rx_busy    <= ser_stat.rx_busy;
			out_item_q.rx_head    <= fifo_stat.head;
			out_item_q.rx_count   <= fifo_stat.count;
			out_item_q.rx_dropped <= fifo_stat.dropped;
		end
	end

endmodule

`default_nettype wire
